@@ src/epsc_pkg.sv @@
// ---------------------------------------------------------------------------
// epsc_pkg: shared definitions for the event plane shift correction block
// Defaults, codes, sequencer states and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epsc_pkg;

  // Default sizes
  localparam int TERMS_DEF        = 20;
  localparam int RUN_SLOTS_DEF    = 64;
  localparam int CENT_CLASSES_DEF = 9;
  localparam int ANGLE_BITS_DEF   = 16;

  localparam int DETECTORS    = 3;
  localparam int CORDIC_STEPS = 30;

  // CORDIC start value with gain compensation (Q30) and 1/pi (Q32)
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
  localparam logic [31:0] INV_PI      = 32'd1367130551;

  localparam logic [4:0] TERMS_USED_RST = 5'd20;

  // Request commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEC,
    ST_PSI,
    ST_DIV,
    ST_DIVEND,
    ST_TERM,
    ST_ROTI,
    ST_ROT,
    ST_MULA,
    ST_MULB,
    ST_MULLO,
    ST_MULHI,
    ST_PREP,
    ST_WRAP
  } state_t;

  // atan(2^-i) in units of a 2^32 full turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10680094;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ src/epsc_req_if.sv @@
// ---------------------------------------------------------------------------
// epsc_req_if: request channel
// Valid/ready channel carrying one load or correct request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface epsc_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [1:0]         detector_select;
  logic [1:0]         harmonic_order;
  logic signed [23:0] qx;
  logic signed [23:0] qy;
  logic [3:0]         centrality;
  logic [5:0]         run_slot;
  logic [4:0]         term_index;
  logic signed [15:0] coef_cos;
  logic signed [15:0] coef_sin;

  modport source (
    output valid, command, detector_select, harmonic_order, qx, qy,
           centrality, run_slot, term_index, coef_cos, coef_sin,
    input  ready
  );

  modport sink (
    input  valid, command, detector_select, harmonic_order, qx, qy,
           centrality, run_slot, term_index, coef_cos, coef_sin,
    output ready
  );
endinterface

`default_nettype wire

@@ src/epsc_res_if.sv @@
// ---------------------------------------------------------------------------
// epsc_res_if: result channel
// Valid/ready channel carrying the corrected and raw event plane angles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface epsc_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] psi_corrected;
  logic signed [15:0] psi_uncorrected;

  modport source (
    output valid, psi_corrected, psi_uncorrected,
    input  ready
  );

  modport sink (
    input  valid, psi_corrected, psi_uncorrected,
    output ready
  );
endinterface

`default_nettype wire

@@ src/event_plane_shift_correction.sv @@
// ---------------------------------------------------------------------------
// event_plane_shift_correction: Fourier shift correction of event planes
// Coefficient table load and iterative per-event angle correction.
// ---------------------------------------------------------------------------
// Usage:
//   request: load (command 0) writes one cos/sin pair into the coefficient
//     memory in the cycle it is accepted; ready stays high, no result.
//   request: correct (command 1) returns one result on the result channel.
//   cfg_wr_en/cfg_wr_data set terms_used (reset value 20); write while idle.
// A correct request runs the vectoring CORDIC (skipped for a zero Q
//   vector) and the division by the order, then for each summed term a
//   rotation CORDIC, two products, 1/pi scaling and a division by
//   n*(k+1), and last the wrap. A new request is taken only after the
//   wrap of the last; the shared CORDIC and the one-bit-per-cycle divider
//   serve one correct request at a time.
// A result waits in an output register while the receiver stalls; a new
//   request is still taken, but the next result waits for the register.
// Reset clears the sequencer and the output valid; the coefficient memory
//   is not cleared and must be loaded before it is used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module event_plane_shift_correction #(
  parameter int TERMS        = epsc_pkg::TERMS_DEF,
  parameter int RUN_SLOTS    = epsc_pkg::RUN_SLOTS_DEF,
  parameter int CENT_CLASSES = epsc_pkg::CENT_CLASSES_DEF,
  parameter int ANGLE_BITS   = epsc_pkg::ANGLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [4:0] cfg_wr_data,
  epsc_req_if.sink        request,
  epsc_res_if.source      result
);

  localparam int AB    = ANGLE_BITS;
  localparam int SH32  = 32 - AB;
  localparam int SCL   = 62 - AB;
  localparam int DEPTH = epsc_pkg::DETECTORS * CENT_CLASSES * RUN_SLOTS * TERMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(TERMS + 1);
  localparam int MW    = $clog2(3 * TERMS + 1);
  localparam int W     = AB + 2;
  localparam int DCW   = $clog2(W);
  localparam int CW    = 43;
  localparam int PSI_W = AB + 1;
  localparam int DW    = AB + 7;
  localparam int RW    = AB + 8;
  localparam int PW    = 35;
  localparam int PRW   = 66;

  localparam logic signed [RW-1:0] LIM1 = RW'(1) <<< (AB - 1);
  localparam logic signed [RW-1:0] LIM2 = RW'(1) <<< (AB - 2);
  localparam logic signed [RW-1:0] LIM3 = RW'((1 << (AB - 1)) / 3);
  localparam logic signed [RW-1:0] PER1 = RW'(1) <<< AB;
  localparam logic signed [RW-1:0] PER2 = RW'(1) <<< (AB - 1);
  localparam logic signed [RW-1:0] PER3 = RW'((1 << AB) / 3);
  localparam logic signed [31:0]   QTURN = 32'sd1073741824;

  epsc_pkg::state_t state, state_next;

  logic [4:0]              terms_used;
  logic [1:0]              n;
  logic [AW-1:0]           base;
  logic                    addr_ok;
  logic [KW-1:0]           cnt;
  logic [KW-1:0]           k;
  logic [MW-1:0]           m;
  logic [4:0]              step;
  logic signed [CW-1:0]    cx, cy;
  logic signed [31:0]      cz;
  logic                    flip;
  logic [W-1:0]            dq;
  logic [MW-1:0]           drem, dden;
  logic                    dneg;
  logic [DCW-1:0]          dcnt;
  logic                    div_psi;
  logic signed [PSI_W-1:0] psi;
  logic signed [DW-1:0]    delta;
  logic signed [48:0]      pa;
  logic signed [PW-1:0]    p;
  logic [46:0]             lo;
  logic signed [PRW-1:0]   prod;
  logic [31:0]             rd_data;
  logic [31:0]             mem [DEPTH];
  logic                    res_valid;
  logic [15:0]             psi_c, psi_u;

  // Request decode
  logic          req_fire, is_load, is_corr;
  logic [AW-1:0] in_row, in_base, wr_addr;
  logic          in_addr_ok, load_ok, q_zero;
  logic [1:0]    n_in;
  logic [KW-1:0] cnt_in;
  logic signed [CW-1:0] x0, y0;

  assign req_fire = request.valid && request.ready;
  assign is_load  = req_fire && (request.command == epsc_pkg::CMD_LOAD);
  assign is_corr  = req_fire && (request.command == epsc_pkg::CMD_CORRECT);

  assign in_row  = AW'((AW'(request.detector_select) * AW'(CENT_CLASSES)
                       + AW'(request.centrality)) * AW'(RUN_SLOTS)
                       + AW'(request.run_slot));
  assign in_base = AW'(in_row * AW'(TERMS));
  assign wr_addr = AW'(in_base + AW'(request.term_index));

  assign in_addr_ok = (request.detector_select < 2'(epsc_pkg::DETECTORS))
                   && ({1'b0, request.centrality} < 5'(CENT_CLASSES))
                   && (13'(request.run_slot) < 13'(RUN_SLOTS));
  assign load_ok = in_addr_ok && (6'(request.term_index) < 6'(TERMS));
  assign q_zero  = (request.qx == 24'sd0) && (request.qy == 24'sd0);
  assign n_in    = (request.harmonic_order == 2'd0) ? 2'd1 : request.harmonic_order;
  assign cnt_in  = ({1'b0, terms_used} < 6'(TERMS)) ? KW'(terms_used) : KW'(TERMS);
  assign x0      = {{(CW - 40){request.qx[23]}}, request.qx, 16'd0};
  assign y0      = {{(CW - 40){request.qy[23]}}, request.qy, 16'd0};

  // Shared CORDIC step: vectoring drives y to zero, rotation drives z to zero
  logic [31:0]          atan;
  logic signed [CW-1:0] xs, ys, x_nx, y_nx;
  logic signed [31:0]   z_nx;
  logic                 rot_pos;

  assign atan    = epsc_pkg::atan_lut(step);
  assign xs      = cx >>> step;
  assign ys      = cy >>> step;
  assign rot_pos = (state == epsc_pkg::ST_VEC) ? cy[CW-1] : !cz[31];
  assign x_nx    = rot_pos ? cx - ys : cx + ys;
  assign y_nx    = rot_pos ? cy + xs : cy - xs;
  assign z_nx    = rot_pos ? cz - $signed(atan) : cz + $signed(atan);

  // Shared restoring divider, one quotient bit per cycle
  logic [MW:0]        dtrial;
  logic               dge;
  logic [MW-1:0]      drem_nx;
  logic signed [W:0]  dres;

  assign dtrial  = {drem, dq[W-1]};
  assign dge     = dtrial >= {1'b0, dden};
  assign drem_nx = dge ? MW'(dtrial - {1'b0, dden}) : dtrial[MW-1:0];
  assign dres    = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

  // psi = round(angle / (n * 2^SH32)): shift first, then floor divide by n
  logic [33:0]       n_half, a_psi;
  logic [W-1:0]      v_psi, w_psi;

  assign n_half = 34'(n) << (SH32 - 1);
  assign a_psi  = {{2{cz[31]}}, cz} + n_half;
  assign v_psi  = a_psi[33:SH32];
  assign w_psi  = v_psi[W-1] ? W'(~v_psi + W'(n)) : v_psi;

  // Term angle n*(k+1)*psi as a 32-bit turn, folded into plus or minus pi/2
  logic [AB-1:0] theta;
  logic [31:0]   t32, t_adj;
  logic          big;

  assign theta = AB'(psi[AB-1:0] * AB'(m));
  assign t32   = {theta, {SH32{1'b0}}};
  assign big   = ($signed(t32) > QTURN) || ($signed(t32) < -QTURN);
  assign t_adj = big ? (t32 ^ 32'h8000_0000) : t32;

  // Term products
  logic signed [CW-1:0] cx_f, cy_f;
  logic signed [32:0]   cv, sv;
  logic signed [15:0]   cc, ss;
  logic signed [48:0]   pa_nx, pb;
  logic signed [49:0]   pdiff;
  logic signed [51:0]   hi;
  logic signed [PRW-1:0] prod_nx;

  assign cx_f    = flip ? -cx : cx;
  assign cy_f    = flip ? -cy : cy;
  assign cv      = cx_f[32:0];
  assign sv      = cy_f[32:0];
  assign cc      = $signed(rd_data[31:16]);
  assign ss      = $signed(rd_data[15:0]);
  assign pa_nx   = cc * sv;
  assign pb      = ss * cv;
  assign pdiff   = {pa[48], pa} - {pb[48], pb};
  assign hi      = $signed(p[PW-1:16]) * $signed({1'b0, epsc_pkg::INV_PI});
  assign prod_nx = ({{(PRW - 52){hi[51]}}, hi} <<< 16) + $signed({{(PRW - 47){1'b0}}, lo});

  // Term quotient numerator: round(prod / (m * 2^SCL)) via shift then divide
  logic [PRW-1:0]    tsum;
  logic [AB+3:0]     v_t, w_tf;

  assign tsum = prod + (PRW'(m) << (SCL - 1));
  assign v_t  = tsum[PRW-1:SCL];
  assign w_tf = v_t[AB+3] ? (~v_t + (AB + 4)'(m)) : v_t;

  // Single wrap into plus or minus pi/n
  logic signed [RW-1:0] raw, raw_w, lim, per, psi_x;

  assign psi_x = RW'(psi);
  assign raw   = psi_x + RW'(delta);

  always_comb begin
    case (n)
      2'd2:    begin lim = LIM2; per = PER2; end
      2'd3:    begin lim = LIM3; per = PER3; end
      default: begin lim = LIM1; per = PER1; end
    endcase
    if (raw > lim) begin
      raw_w = raw - per;
    end else if (raw < -lim) begin
      raw_w = raw + per;
    end else begin
      raw_w = raw;
    end
  end

  // Rescale to 16-bit binary angles
  logic [15:0] out_c, out_u;

  if (AB > 16) begin : g_round
    localparam int SH = AB - 16;
    logic signed [RW:0] rc, ru;
    assign rc    = {raw_w[RW-1], raw_w} + (RW + 1)'(1 << (SH - 1));
    assign ru    = {psi_x[RW-1], psi_x} + (RW + 1)'(1 << (SH - 1));
    assign out_c = rc[SH+15:SH];
    assign out_u = ru[SH+15:SH];
  end else if (AB < 16) begin : g_widen
    assign out_c = {raw_w[AB-1:0], {(16 - AB){1'b0}}};
    assign out_u = {psi_x[AB-1:0], {(16 - AB){1'b0}}};
  end else begin : g_same
    assign out_c = raw_w[15:0];
    assign out_u = psi_x[15:0];
  end

  logic out_free, k_last;
  assign out_free = !res_valid || result.ready;
  assign k_last   = (KW'(k + KW'(1)) == cnt);

  // Sequencer: next state and handshake outputs
  always_comb begin
    state_next    = state;
    request.ready = (state == epsc_pkg::ST_IDLE);
    case (state)
      epsc_pkg::ST_IDLE: begin
        if (is_corr) begin
          state_next = q_zero ? epsc_pkg::ST_PSI : epsc_pkg::ST_VEC;
        end
      end
      epsc_pkg::ST_VEC: begin
        if (step == 5'(epsc_pkg::CORDIC_STEPS - 1)) state_next = epsc_pkg::ST_PSI;
      end
      epsc_pkg::ST_PSI:  state_next = epsc_pkg::ST_DIV;
      epsc_pkg::ST_DIV: begin
        if (dcnt == DCW'(W - 1)) state_next = epsc_pkg::ST_DIVEND;
      end
      epsc_pkg::ST_DIVEND: begin
        if (div_psi) begin
          state_next = (addr_ok && cnt != '0) ? epsc_pkg::ST_TERM : epsc_pkg::ST_WRAP;
        end else begin
          state_next = k_last ? epsc_pkg::ST_WRAP : epsc_pkg::ST_TERM;
        end
      end
      epsc_pkg::ST_TERM:  state_next = epsc_pkg::ST_ROTI;
      epsc_pkg::ST_ROTI:  state_next = epsc_pkg::ST_ROT;
      epsc_pkg::ST_ROT: begin
        if (step == 5'(epsc_pkg::CORDIC_STEPS - 1)) state_next = epsc_pkg::ST_MULA;
      end
      epsc_pkg::ST_MULA:  state_next = epsc_pkg::ST_MULB;
      epsc_pkg::ST_MULB:  state_next = epsc_pkg::ST_MULLO;
      epsc_pkg::ST_MULLO: state_next = epsc_pkg::ST_MULHI;
      epsc_pkg::ST_MULHI: state_next = epsc_pkg::ST_PREP;
      epsc_pkg::ST_PREP:  state_next = epsc_pkg::ST_DIV;
      epsc_pkg::ST_WRAP: begin
        if (out_free) state_next = epsc_pkg::ST_IDLE;
      end
      default: state_next = epsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      terms_used <= epsc_pkg::TERMS_USED_RST;
    end else if (cfg_wr_en) begin
      terms_used <= cfg_wr_data;
    end
  end

  // Coefficient memory: cos in the high half, sin in the low half
  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      mem[wr_addr] <= {request.coef_cos, request.coef_sin};
    end
    if (state == epsc_pkg::ST_TERM) begin
      rd_data <= mem[AW'(base + AW'(k))];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      epsc_pkg::ST_IDLE: begin
        if (is_corr) begin
          n       <= n_in;
          base    <= in_base;
          addr_ok <= in_addr_ok;
          cnt     <= cnt_in;
          k       <= '0;
          step    <= '0;
          if (request.qx[23]) begin
            cx <= -x0;
            cy <= -y0;
            cz <= 32'sh8000_0000;
          end else begin
            cx <= x0;
            cy <= y0;
            cz <= '0;
          end
        end
      end
      epsc_pkg::ST_VEC, epsc_pkg::ST_ROT: begin
        cx   <= x_nx;
        cy   <= y_nx;
        cz   <= z_nx;
        step <= step + 5'd1;
      end
      epsc_pkg::ST_PSI: begin
        dq      <= w_psi;
        dneg    <= v_psi[W-1];
        dden    <= MW'(n);
        drem    <= '0;
        dcnt    <= '0;
        div_psi <= 1'b1;
      end
      epsc_pkg::ST_DIV: begin
        dq   <= {dq[W-2:0], dge};
        drem <= drem_nx;
        dcnt <= dcnt + DCW'(1);
      end
      epsc_pkg::ST_DIVEND: begin
        if (div_psi) begin
          psi   <= PSI_W'(dres);
          delta <= '0;
        end else begin
          delta <= delta + DW'(dres);
          k     <= k + KW'(1);
        end
      end
      epsc_pkg::ST_TERM: begin
        m <= MW'(MW'(n) * (MW'(k) + MW'(1)));
      end
      epsc_pkg::ST_ROTI: begin
        cz   <= $signed(t_adj);
        flip <= big;
        cx   <= CW'(epsc_pkg::CORDIC_GAIN);
        cy   <= '0;
        step <= '0;
      end
      epsc_pkg::ST_MULA:  pa   <= pa_nx;
      epsc_pkg::ST_MULB:  p    <= pdiff[49:15];
      epsc_pkg::ST_MULLO: lo   <= 47'(p[15:0]) * 47'(epsc_pkg::INV_PI);
      epsc_pkg::ST_MULHI: prod <= prod_nx;
      epsc_pkg::ST_PREP: begin
        dq      <= w_tf[W-1:0];
        dneg    <= v_t[AB+3];
        dden    <= m;
        drem    <= '0;
        dcnt    <= '0;
        div_psi <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == epsc_pkg::ST_WRAP && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == epsc_pkg::ST_WRAP && out_free) begin
      psi_c <= out_c;
      psi_u <= out_u;
    end
  end

  assign result.valid           = res_valid;
  assign result.psi_corrected   = psi_c;
  assign result.psi_uncorrected = psi_u;

endmodule

`default_nettype wire

@@ src/epsc_checker.sv @@
// ---------------------------------------------------------------------------
// epsc_checker: port-level checks for the shift correction block
// Sequencing of requests against results, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        req_command,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [15:0] psi_c,
  input wire logic [15:0] psi_u
);

  // A correct request keeps the block busy
  a_corr_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == epsc_pkg::CMD_CORRECT |=> !req_ready)
    else $error("ready high right after a correct request");

  // A load finishes in its accept cycle
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == epsc_pkg::CMD_LOAD |=> req_ready)
    else $error("ready dropped after a load request");

  // Results appear only at the end of busy work
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> !$past(req_ready))
    else $error("result raised while idle");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(psi_c) && $stable(psi_u))
    else $error("stalled result changed");

endmodule

bind event_plane_shift_correction epsc_checker u_epsc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .psi_c       (result.psi_corrected),
  .psi_u       (result.psi_uncorrected)
);

`default_nettype wire
